FILE: sv/u2u_pkg.sv
// shared types, codes and constants for the utf-8 to utf-16 stream decoder
package u2u_pkg;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_TRUNC    = 2'd2,
    ST_CAPACITY = 2'd3
  } status_t;

  // register map
  localparam int unsigned REG_W       = 32;
  localparam int unsigned ADDR_W      = 3;
  localparam logic        REG_OUT_CAP = 1'b0;
  localparam logic [15:0] CAP_RESET   = 16'hFFFF;

  // byte class masks and patterns
  localparam logic [7:0] MASK_ASCII = 8'h80;
  localparam logic [7:0] MASK_LEAD2 = 8'hE0;
  localparam logic [7:0] PAT_LEAD2  = 8'hC0;
  localparam logic [7:0] MASK_LEAD3 = 8'hF0;
  localparam logic [7:0] PAT_LEAD3  = 8'hE0;
  localparam logic [7:0] MASK_CONT  = 8'hC0;
  localparam logic [7:0] PAT_CONT   = 8'h80;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       first_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        unit_valid;
    logic        done_res;
    status_t     status;
    logic [15:0] unit_count;
  } out_word_t;

  typedef struct packed {
    logic [15:0] partial_value;
    logic [1:0]  bytes_pending;
    logic        stopped;
    logic [15:0] units_emitted;
  } dec_state_t;

endpackage

FILE: sv/u2u_cfg.sv
// apb-style configuration register block holding the output capacity
module u2u_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [u2u_pkg::ADDR_W-1:0]  paddr,
  input  logic [u2u_pkg::REG_W-1:0]   pwdata,
  output logic [u2u_pkg::REG_W-1:0]   prdata,
  output logic                        pready,
  output logic [15:0]                 capacity
);

  logic [15:0] cap_r;
  logic [15:0] cap_nxt;
  logic        wr_en;
  logic        reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[u2u_pkg::ADDR_W-1];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    cap_nxt = cap_r;
    if (wr_en && (reg_idx == u2u_pkg::REG_OUT_CAP)) begin
      cap_nxt = pwdata[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= u2u_pkg::CAP_RESET;
    end else begin
      cap_r <= cap_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == u2u_pkg::REG_OUT_CAP) begin
      prdata = {{(u2u_pkg::REG_W-16){1'b0}}, cap_r};
    end
  end

  assign capacity = cap_r;

endmodule

FILE: sv/u2u_step.sv
// combinational decode of one byte against the current string state
module u2u_step (
  input  u2u_pkg::in_word_t   item,
  input  u2u_pkg::dec_state_t cur,
  input  logic [15:0]         capacity,
  output u2u_pkg::dec_state_t nxt,
  output u2u_pkg::out_word_t  res,
  output logic                res_valid
);

  logic [7:0] b;
  logic       valid;
  logic       done;
  logic [15:0] unit;
  u2u_pkg::status_t st;
  u2u_pkg::dec_state_t s;

  assign b = item.byte_in;

  always_comb begin
    s     = cur;
    valid = 1'b0;
    done  = 1'b0;
    unit  = '0;
    st    = u2u_pkg::ST_OK;

    // first mark clears the string and restarts decoding
    if (item.first_byte) begin
      s.partial_value = '0;
      s.bytes_pending = '0;
      s.units_emitted = '0;
      s.stopped       = 1'b0;
    end

    if (!s.stopped) begin
      if (s.bytes_pending == 2'd0) begin
        if (s.units_emitted >= capacity) begin
          done = 1'b1;
          st   = u2u_pkg::ST_CAPACITY;
        end else if ((b & u2u_pkg::MASK_ASCII) == 8'h00) begin
          unit  = {8'h00, b};
          valid = 1'b1;
        end else if ((b & u2u_pkg::MASK_LEAD2) == u2u_pkg::PAT_LEAD2) begin
          s.partial_value = {5'b0, b[4:0], 6'b0};
          s.bytes_pending = 2'd1;
        end else if ((b & u2u_pkg::MASK_LEAD3) == u2u_pkg::PAT_LEAD3) begin
          s.partial_value = {b[3:0], 12'b0};
          s.bytes_pending = 2'd2;
        end else begin
          done = 1'b1;
          st   = u2u_pkg::ST_INVALID;
        end
      end else if ((b & u2u_pkg::MASK_CONT) != u2u_pkg::PAT_CONT) begin
        done = 1'b1;
        st   = u2u_pkg::ST_INVALID;
      end else if (s.bytes_pending == 2'd2) begin
        s.partial_value = s.partial_value | {4'b0, b[5:0], 6'b0};
        s.bytes_pending = 2'd1;
      end else begin
        unit            = s.partial_value | {10'b0, b[5:0]};
        valid           = 1'b1;
        s.bytes_pending = 2'd0;
        s.partial_value = '0;
      end

      if (valid) begin
        s.units_emitted = s.units_emitted + 16'd1;
      end

      if (!done && item.last_byte) begin
        done = 1'b1;
        st   = (s.bytes_pending != 2'd0) ? u2u_pkg::ST_TRUNC : u2u_pkg::ST_OK;
      end

      if (done) begin
        s.stopped       = 1'b1;
        s.bytes_pending = '0;
        s.partial_value = '0;
      end
    end
  end

  assign nxt            = s;
  assign res_valid      = valid || done;
  assign res.code_unit  = unit;
  assign res.unit_valid = valid;
  assign res.done_res   = done;
  assign res.status     = st;
  assign res.unit_count = s.units_emitted;

endmodule

FILE: sv/u2u_core.sv
// input register, string state, decode step and result register
module u2u_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  u2u_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output u2u_pkg::out_word_t out_data,
  input  logic [15:0]        capacity
);

  logic                s1_valid_r;
  logic                s1_valid_nxt;
  u2u_pkg::in_word_t   s1_data_r;
  u2u_pkg::dec_state_t state_r;
  u2u_pkg::dec_state_t state_nxt;
  u2u_pkg::dec_state_t step_state;
  u2u_pkg::out_word_t  step_res;
  logic                step_res_valid;
  logic                out_valid_r;
  logic                out_valid_nxt;
  u2u_pkg::out_word_t  out_data_r;
  logic                out_free;
  logic                advance;
  logic                in_take;

  u2u_step u_step (
    .item      (s1_data_r),
    .cur       (state_r),
    .capacity  (capacity),
    .nxt       (step_state),
    .res       (step_res),
    .res_valid (step_res_valid)
  );

  // a word with no result may move on even while the result register is held
  assign out_free = !out_valid_r || !out_stall;
  assign advance  = s1_valid_r && (out_free || !step_res_valid);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    state_nxt = advance ? step_state : state_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (advance && step_res_valid) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r            <= 1'b0;
      out_valid_r           <= 1'b0;
      state_r.partial_value <= '0;
      state_r.bytes_pending <= '0;
      state_r.stopped       <= 1'b1;
      state_r.units_emitted <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      state_r     <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data;
    end
    if (advance && step_res_valid) begin
      out_data_r <= step_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_no_pending3 : assert property (@(posedge clk) disable iff (!rst_n)
    state_r.bytes_pending != 2'd3)
    else $error("three continuation bytes pending");

  a_done_stops : assert property (@(posedge clk) disable iff (!rst_n)
    advance && step_res_valid && step_res.done_res |=> state_r.stopped)
    else $error("decoder not stopped after done");

  a_stopped_idle : assert property (@(posedge clk) disable iff (!rst_n)
    state_r.stopped |-> (state_r.bytes_pending == 2'd0) && (state_r.partial_value == 16'd0))
    else $error("stopped with a partial sequence");

  a_status_done : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.done_res |-> out_data_r.status == u2u_pkg::ST_OK)
    else $error("status set without done");

  a_unit_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.unit_valid |-> out_data_r.code_unit == 16'd0)
    else $error("code unit nonzero without a unit");

  a_result_lands : assert property (@(posedge clk) disable iff (!rst_n)
    advance && step_res_valid |=> out_valid_r)
    else $error("result lost on its way to the output");

endmodule

FILE: sv/utf8_to_utf16_stream_decoder.sv
// top level of the utf-8 to utf-16 stream decoder
//
//  channel | ports                              | moves
//  --------+------------------------------------+----------------------------------
//  in      | in_valid, in_stall, in_data        | one utf-8 byte with first/last marks
//  out     | out_valid, out_stall, out_data     | one result word: unit and/or done
//  cfg     | psel penable pwrite paddr pwdata   | output_capacity at byte addresses 0 to 3
//          | prdata pready                      |
//
// one input word per clock sustained while no held result blocks it; a word waits in the input
// register, is decoded against the string state on the way to the result
// register and can be taken at the out port from there.
// rst_n is synchronous, active low: the decoder waits for a first mark and the
// capacity returns to 65535.
// a held result stalls only words that produce a result; words with none pass.
// a write to any address other than the capacity register is ignored.
module utf8_to_utf16_stream_decoder (
  input  logic                        clk,
  input  logic                        rst_n,
  // input byte channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  u2u_pkg::in_word_t           in_data,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output u2u_pkg::out_word_t          out_data,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [u2u_pkg::ADDR_W-1:0]  paddr,
  input  logic [u2u_pkg::REG_W-1:0]   pwdata,
  output logic [u2u_pkg::REG_W-1:0]   prdata,
  output logic                        pready
);

  // capacity value; the user must keep the decoder idle during writes, the block does not enforce it
  logic [15:0] capacity;

  u2u_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .capacity (capacity)
  );

  // decoding datapath with its own input and result registers
  u2u_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .capacity  (capacity)
  );

endmodule

FILE: tb/u2u_decode_checker.sv
// checker for the utf-8 to utf-16 stream decoder: predicts result words and compares them
`timescale 1ns / 100ps

module u2u_decode_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  u2u_pkg::in_word_t            in_data,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  u2u_pkg::out_word_t           out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [u2u_pkg::ADDR_W-1:0]   paddr,
  input  logic [u2u_pkg::REG_W-1:0]    pwdata,
  input  logic                         pready,
  output int                           mismatches,
  output int                           units_awaited
);

  localparam int unsigned CAP_BYTE = 4 * u2u_pkg::REG_OUT_CAP;
  localparam logic [u2u_pkg::ADDR_W-1:0] CAP_ADDR = CAP_BYTE[u2u_pkg::ADDR_W-1:0];

  // own copy of the string state and the capacity register
  logic [15:0] capacity;
  logic [15:0] partial;
  logic [1:0]  pend;
  logic        halted;
  logic [15:0] emitted;

  u2u_pkg::out_word_t decoded_words[$];

  initial mismatches = 0;

  task automatic flag_mismatch(input string msg);
    $display("[%0t] decode mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // decodes one accepted byte against the string state; 1 when it yields a word
  function automatic bit decode_byte(input u2u_pkg::in_word_t w,
                                     output u2u_pkg::out_word_t r);
    logic [7:0] b;
    b = w.byte_in;
    r = '0;
    if (w.first_byte) begin
      partial = '0;
      pend    = '0;
      emitted = '0;
      halted  = 1'b0;
    end
    if (halted) return 1'b0;

    if (pend == 2'd0) begin
      if (emitted >= capacity) begin
        r.done_res = 1'b1;
        r.status   = u2u_pkg::ST_CAPACITY;
      end else if ((b & u2u_pkg::MASK_ASCII) == 8'h00) begin
        r.code_unit  = {8'h00, b};
        r.unit_valid = 1'b1;
      end else if ((b & u2u_pkg::MASK_LEAD2) == u2u_pkg::PAT_LEAD2) begin
        partial = {5'd0, b[4:0], 6'd0};
        pend    = 2'd1;
      end else if ((b & u2u_pkg::MASK_LEAD3) == u2u_pkg::PAT_LEAD3) begin
        partial = {b[3:0], 12'd0};
        pend    = 2'd2;
      end else begin
        r.done_res = 1'b1;
        r.status   = u2u_pkg::ST_INVALID;
      end
    end else if ((b & u2u_pkg::MASK_CONT) != u2u_pkg::PAT_CONT) begin
      r.done_res = 1'b1;
      r.status   = u2u_pkg::ST_INVALID;
    end else if (pend == 2'd2) begin
      partial = partial | {4'd0, b[5:0], 6'd0};
      pend    = 2'd1;
    end else begin
      r.code_unit  = partial | {10'd0, b[5:0]};
      r.unit_valid = 1'b1;
      pend         = 2'd0;
      partial      = '0;
    end

    if (r.unit_valid) emitted = emitted + 16'd1;

    if (!r.done_res && w.last_byte) begin
      r.done_res = 1'b1;
      r.status   = (pend != 2'd0) ? u2u_pkg::ST_TRUNC : u2u_pkg::ST_OK;
    end

    if (r.done_res) begin
      halted  = 1'b1;
      pend    = '0;
      partial = '0;
    end

    r.unit_count = emitted;
    return r.unit_valid || r.done_res;
  endfunction

  always @(posedge clk) begin
    u2u_pkg::out_word_t want;
    u2u_pkg::out_word_t got;
    if (!rst_n) begin
      capacity = u2u_pkg::CAP_RESET;
      partial  = '0;
      pend     = '0;
      halted   = 1'b1;
      emitted  = '0;
      decoded_words.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = out_data;
        if (decoded_words.size() == 0) begin
          flag_mismatch($sformatf("word %h with nothing expected", got));
        end else begin
          want = decoded_words.pop_front();
          if (got.code_unit !== want.code_unit)
            flag_mismatch($sformatf("code_unit %h, want %h", got.code_unit, want.code_unit));
          if (got.unit_valid !== want.unit_valid)
            flag_mismatch($sformatf("unit_valid %b, want %b", got.unit_valid, want.unit_valid));
          if (got.done_res !== want.done_res)
            flag_mismatch($sformatf("done_res %b, want %b", got.done_res, want.done_res));
          if (got.status !== want.status)
            flag_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
          if (got.unit_count !== want.unit_count)
            flag_mismatch($sformatf("unit_count %0d, want %0d", got.unit_count,
                                    want.unit_count));
        end
      end
      if (in_valid && !in_stall) begin
        if (decode_byte(in_data, want)) decoded_words.push_back(want);
      end
      if (psel && penable && pwrite && pready && paddr == CAP_ADDR)
        capacity = pwdata[15:0];
    end
    units_awaited <= decoded_words.size();
  end

endmodule

FILE: tb/utf8_to_utf16_stream_decoder_tb.sv
// testbench top for the utf-8 to utf-16 stream decoder: byte stimulus, capacity phases, verdict
`timescale 1ns / 100ps

module utf8_to_utf16_stream_decoder_tb;

  localparam int unsigned CAP_BYTE = 4 * u2u_pkg::REG_OUT_CAP;
  localparam logic [u2u_pkg::ADDR_W-1:0] CAP_ADDR = CAP_BYTE[u2u_pkg::ADDR_W-1:0];
  localparam int PHASE_WORDS = 140;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  u2u_pkg::in_word_t           in_data;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  u2u_pkg::out_word_t          out_data;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [u2u_pkg::ADDR_W-1:0]  paddr;
  logic [u2u_pkg::REG_W-1:0]   pwdata;
  logic [u2u_pkg::REG_W-1:0]   prdata;
  logic                        pready;

  int                 mismatches;
  int                 units_awaited;
  int                 words_sent = 0;
  // when set neither side idles: the long back-to-back stretch
  bit                 calm = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  utf8_to_utf16_stream_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  u2u_decode_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .mismatches    (mismatches),
    .units_awaited (units_awaited)
  );

  // receiver back-pressure: random stall about 38% of cycles, none while calm
  always @(negedge clk) begin
    out_stall <= rst_n && !calm && ($urandom_range(99) < 38);
  end

  // drives one word, called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so a following word goes out back to back
  task automatic push_byte(input logic [7:0] b, input logic first, input logic last);
    while (!calm && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{byte_in: b, first_byte: first, last_byte: last};
    do @(posedge clk); while (in_stall);
    words_sent++;
    @(negedge clk);
  endtask

  // drops valid and waits for every predicted word, then for the pipeline to empty
  task automatic drain();
    in_valid <= 1'b0;
    while (units_awaited != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // setup then access phase; register takes the value on the access edge
  task automatic write_capacity(input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAP_ADDR;
    pwdata  <= {{(u2u_pkg::REG_W-16){1'b0}}, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(63));
  endfunction

  // one string: mostly well formed with random characters, the rest broken or noise
  task automatic send_string();
    logic [7:0] bytes_q[$];
    int         nchar;
    int         flavour;
    int         pos;
    int         len;
    bit         marked_end;
    nchar      = $urandom_range(10, 1);
    flavour    = $urandom_range(99);
    marked_end = 1'b1;
    for (int c = 0; c < nchar; c++) begin
      case ($urandom_range(2))
        0: bytes_q.push_back(8'($urandom_range(127)));
        1: begin
          bytes_q.push_back(8'hC0 | 8'($urandom_range(31)));
          bytes_q.push_back(cont_byte());
        end
        default: begin
          bytes_q.push_back(8'hE0 | 8'($urandom_range(15)));
          bytes_q.push_back(cont_byte());
          bytes_q.push_back(cont_byte());
        end
      endcase
    end
    if (flavour < 10) begin
      // one byte corrupted: stray continuation, forbidden lead or plain ascii
      pos = $urandom_range(bytes_q.size() - 1);
      case ($urandom_range(2))
        0:       bytes_q[pos] = cont_byte();
        1:       bytes_q[pos] = 8'hF0 | 8'($urandom_range(15));
        default: bytes_q[pos] = 8'($urandom_range(127));
      endcase
    end else if (flavour < 20) begin
      // string cut short inside a sequence
      if ($urandom_range(1)) begin
        bytes_q.push_back(8'hC0 | 8'($urandom_range(31)));
      end else begin
        bytes_q.push_back(8'hE0 | 8'($urandom_range(15)));
        if ($urandom_range(1)) bytes_q.push_back(cont_byte());
      end
    end else if (flavour < 26) begin
      // raw noise over the whole byte range
      bytes_q.delete();
      len = $urandom_range(6, 1);
      repeat (len) bytes_q.push_back(8'($urandom_range(255)));
    end else if (flavour < 32) begin
      // no last mark: the next first mark has to clear the state
      marked_end = 1'b0;
    end
    foreach (bytes_q[i])
      push_byte(bytes_q[i], i == 0, marked_end && i == bytes_q.size() - 1);
    // occasional bytes without a first mark between strings
    if ($urandom_range(9) == 0) begin
      len = $urandom_range(3, 1);
      repeat (len) push_byte(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
    end
  endtask

  initial begin
    logic [15:0] caps[6];
    int          target;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    caps[0]  = 16'hFFFF;
    caps[1]  = 16'd1;
    caps[2]  = 16'($urandom_range(6, 2));
    caps[3]  = 16'($urandom_range(65534, 7));
    caps[4]  = 16'd3;
    caps[5]  = 16'hFFFF;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part, capacity still at its reset value
    push_byte(8'h41, 1'b0, 1'b0);   // no first mark since reset: ignored
    push_byte(8'h00, 1'b1, 1'b1);   // one-byte string, unit and done together
    push_byte(8'h7F, 1'b1, 1'b0);   // largest ascii
    push_byte(8'hDF, 1'b0, 1'b0);   // largest two-byte value
    push_byte(8'hBF, 1'b0, 1'b0);
    push_byte(8'hEF, 1'b0, 1'b0);   // largest three-byte value, done on its last byte
    push_byte(8'hBF, 1'b0, 1'b0);
    push_byte(8'hBF, 1'b0, 1'b1);
    push_byte(8'hED, 1'b1, 1'b0);   // surrogate value passes straight through
    push_byte(8'hA0, 1'b0, 1'b0);
    push_byte(8'h80, 1'b0, 1'b1);
    push_byte(8'hC0, 1'b1, 1'b1);   // lead on the last byte: truncated
    push_byte(8'h80, 1'b1, 1'b0);   // continuation in lead position
    push_byte(8'h41, 1'b0, 1'b1);   // ignored after the stop
    push_byte(8'hFF, 1'b1, 1'b1);   // forbidden lead on the last byte: invalid beats end
    push_byte(8'hC3, 1'b1, 1'b0);
    push_byte(8'h41, 1'b0, 1'b1);   // bad continuation on the last byte
    push_byte(8'hE2, 1'b1, 1'b0);
    push_byte(8'h82, 1'b0, 1'b0);
    push_byte(8'h00, 1'b1, 1'b1);   // first mark mid-sequence restarts the string
    push_byte(8'h41, 1'b1, 1'b0);
    push_byte(8'hE2, 1'b0, 1'b0);
    push_byte(8'h82, 1'b0, 1'b0);
    // capacity lowered to the count with a sequence open: the sequence still ends
    drain();
    write_capacity(16'd1);
    push_byte(8'hAC, 1'b0, 1'b0);
    push_byte(8'h41, 1'b0, 1'b1);   // next lead over capacity: stops with capacity status

    // random phases, one capacity setting each; the sender waits out every result between
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      write_capacity(caps[ph]);
      calm   = (ph == 3);
      target = words_sent + PHASE_WORDS;
      while (words_sent < target) send_string();
    end
    calm = 1'b0;

    in_valid <= 1'b0;
    for (int n = 0; n < 20000 && units_awaited != 0; n++) @(negedge clk);
    repeat (8) @(negedge clk);
    if (units_awaited != 0) $display("%0d decoded words never arrived", units_awaited);
    if (mismatches == 0 && units_awaited == 0) begin
      $display("utf8_to_utf16_stream_decoder_tb: clean");
    end else begin
      $display("utf8_to_utf16_stream_decoder_tb: errors");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #1_000_000;
    $display("utf8_to_utf16_stream_decoder_tb: errors");
    $finish;
  end

endmodule

FILE: sim.f
sv/u2u_pkg.sv
sv/u2u_cfg.sv
sv/u2u_step.sv
sv/u2u_core.sv
sv/utf8_to_utf16_stream_decoder.sv
tb/u2u_decode_checker.sv
tb/utf8_to_utf16_stream_decoder_tb.sv
